// ----- rtl/core/tlca_pkg.sv -----
// ----------------------------------------------------------------------------
// tlca_pkg - shared types and constants of the tree ancestor engine
// Request and result items, controller commands, status and state codes.
// ----------------------------------------------------------------------------
package tlca_pkg;

    localparam int NODES_DEF    = 1024;
    localparam int LEVELS_DEF   = 10;
    localparam int NODE_FIELD_W = 10;
    localparam int TIME_W       = 11;
    localparam int DIST_W       = 32;
    localparam int STEP_W       = $clog2(NODE_FIELD_W);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam logic RES_LOAD  = 1'b0;
    localparam logic RES_QUERY = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [NODE_FIELD_W-1:0] node_a;
        logic [NODE_FIELD_W-1:0] node_b;
        logic [TIME_W-1:0]       entry_time;
        logic [TIME_W-1:0]       exit_time;
        logic [DIST_W-1:0]       root_distance;
    } t_req;

    typedef struct packed {
        logic                    result_kind;
        logic [NODE_FIELD_W-1:0] common_ancestor;
        logic [DIST_W-1:0]       path_distance;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_REDUCE, S_LOAD_WR, S_FILL_RD, S_FILL_WR,
        S_QRD_A, S_QRD_B, S_QCAP, S_QCHK,
        S_CL_ANC, S_CL_SPAN, S_CL_TEST,
        S_PAR_RD, S_DIST_RD, S_DCAP, S_FINISH, S_RESULT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_REDUCE, OP_LOAD_WRITE, OP_FILL_READ, OP_FILL_WRITE,
        OP_READ_A, OP_READ_B, OP_CAPTURE_B, OP_CHECK,
        OP_CLIMB_READ, OP_CLIMB_SPAN, OP_CLIMB_TEST,
        OP_PARENT_READ, OP_DIST_READ, OP_DIST_CAPTURE, OP_FINISH, OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic step_last;
        logic lvl_last;
        logic lvl_zero;
        logic contained;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/tlca_stream_if.sv -----
// ----------------------------------------------------------------------------
// tlca_stream_if - valid/ready channel
// Carries one item per accepted handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface tlca_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/tlca_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlca_ctrl - sequencer of the tree ancestor engine
// Steps one item through reduction, then a row fill for a load or a containment check and ancestor climb for a query.
// ----------------------------------------------------------------------------
module tlca_ctrl #(
    parameter int LEVELS = tlca_pkg::LEVELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  tlca_pkg::t_stat i_stat,
    output tlca_pkg::t_cmd  o_cmd
);

    tlca_pkg::t_state r_state;
    tlca_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlca_pkg::S_IDLE: begin
                if (i_req_valid) n_state = tlca_pkg::S_REDUCE;
            end
            tlca_pkg::S_REDUCE: begin
                if (i_stat.step_last) begin
                    n_state = i_stat.is_query ? tlca_pkg::S_QRD_A : tlca_pkg::S_LOAD_WR;
                end
            end
            tlca_pkg::S_LOAD_WR: begin
                n_state = (LEVELS == 1) ? tlca_pkg::S_RESULT : tlca_pkg::S_FILL_RD;
            end
            tlca_pkg::S_FILL_RD: n_state = tlca_pkg::S_FILL_WR;
            tlca_pkg::S_FILL_WR: begin
                n_state = i_stat.lvl_last ? tlca_pkg::S_RESULT : tlca_pkg::S_FILL_RD;
            end
            tlca_pkg::S_QRD_A:   n_state = tlca_pkg::S_QRD_B;
            tlca_pkg::S_QRD_B:   n_state = tlca_pkg::S_QCAP;
            tlca_pkg::S_QCAP:    n_state = tlca_pkg::S_QCHK;
            tlca_pkg::S_QCHK: begin
                n_state = i_stat.contained ? tlca_pkg::S_FINISH : tlca_pkg::S_CL_ANC;
            end
            tlca_pkg::S_CL_ANC:  n_state = tlca_pkg::S_CL_SPAN;
            tlca_pkg::S_CL_SPAN: n_state = tlca_pkg::S_CL_TEST;
            tlca_pkg::S_CL_TEST: begin
                n_state = i_stat.lvl_zero ? tlca_pkg::S_PAR_RD : tlca_pkg::S_CL_ANC;
            end
            tlca_pkg::S_PAR_RD:  n_state = tlca_pkg::S_DIST_RD;
            tlca_pkg::S_DIST_RD: n_state = tlca_pkg::S_DCAP;
            tlca_pkg::S_DCAP:    n_state = tlca_pkg::S_FINISH;
            tlca_pkg::S_FINISH:  n_state = tlca_pkg::S_RESULT;
            tlca_pkg::S_RESULT: begin
                if (i_stat.out_free) n_state = tlca_pkg::S_IDLE;
            end
            default: n_state = tlca_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd.op    = tlca_pkg::OP_NONE;
        case (r_state)
            tlca_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) o_cmd.op = tlca_pkg::OP_CAPTURE;
            end
            tlca_pkg::S_REDUCE:  o_cmd.op = tlca_pkg::OP_REDUCE;
            tlca_pkg::S_LOAD_WR: o_cmd.op = tlca_pkg::OP_LOAD_WRITE;
            tlca_pkg::S_FILL_RD: o_cmd.op = tlca_pkg::OP_FILL_READ;
            tlca_pkg::S_FILL_WR: o_cmd.op = tlca_pkg::OP_FILL_WRITE;
            tlca_pkg::S_QRD_A:   o_cmd.op = tlca_pkg::OP_READ_A;
            tlca_pkg::S_QRD_B:   o_cmd.op = tlca_pkg::OP_READ_B;
            tlca_pkg::S_QCAP:    o_cmd.op = tlca_pkg::OP_CAPTURE_B;
            tlca_pkg::S_QCHK:    o_cmd.op = tlca_pkg::OP_CHECK;
            tlca_pkg::S_CL_ANC:  o_cmd.op = tlca_pkg::OP_CLIMB_READ;
            tlca_pkg::S_CL_SPAN: o_cmd.op = tlca_pkg::OP_CLIMB_SPAN;
            tlca_pkg::S_CL_TEST: o_cmd.op = tlca_pkg::OP_CLIMB_TEST;
            tlca_pkg::S_PAR_RD:  o_cmd.op = tlca_pkg::OP_PARENT_READ;
            tlca_pkg::S_DIST_RD: o_cmd.op = tlca_pkg::OP_DIST_READ;
            tlca_pkg::S_DCAP:    o_cmd.op = tlca_pkg::OP_DIST_CAPTURE;
            tlca_pkg::S_FINISH:  o_cmd.op = tlca_pkg::OP_FINISH;
            tlca_pkg::S_RESULT: begin
                if (i_stat.out_free) o_cmd.op = tlca_pkg::OP_OUT_LOAD;
            end
            default: o_cmd.op = tlca_pkg::OP_NONE;
        endcase
    end

endmodule

// ----- rtl/core/tlca_dpath.sv -----
// ----------------------------------------------------------------------------
// tlca_dpath - datapath of the tree ancestor engine
// Index reduction, ancestor/time/distance memories, climb registers, output.
// ----------------------------------------------------------------------------
module tlca_dpath #(
    parameter int NODES  = tlca_pkg::NODES_DEF,
    parameter int LEVELS = tlca_pkg::LEVELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlca_pkg::t_req  i_req,
    input  tlca_pkg::t_cmd  i_cmd,
    output tlca_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tlca_pkg::t_rsp  o_out
);

    localparam int NW        = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW        = NW + LW;
    localparam int ANC_DEPTH = NODES * (2 ** LW);
    localparam int LIM_W     = NW + tlca_pkg::NODE_FIELD_W + 1;
    localparam int FW        = tlca_pkg::NODE_FIELD_W;
    localparam int TW        = tlca_pkg::TIME_W;
    localparam int DW        = tlca_pkg::DIST_W;

    // memories
    logic [NW-1:0]   r_anc_mem  [ANC_DEPTH];
    logic [2*TW-1:0] r_span_mem [NODES];
    logic [DW-1:0]   r_dist_mem [NODES];

    logic [NW-1:0]   r_anc_q;
    logic [2*TW-1:0] r_span_q;
    logic [DW-1:0]   r_dist_q;

    // item registers
    logic            r_type;
    logic [FW-1:0]   r_ra;
    logic [FW-1:0]   r_rb;
    logic [TW-1:0]   r_entry;
    logic [TW-1:0]   r_exit;
    logic [DW-1:0]   r_rdist;
    logic [tlca_pkg::STEP_W-1:0] r_step;

    // climb registers
    logic [NW-1:0]   r_up;
    logic [NW-1:0]   r_cur;
    logic [NW-1:0]   r_c;
    logic [LW-1:0]   r_lvl;
    logic [TW-1:0]   r_ea, r_xa, r_eb, r_xb;
    logic [DW-1:0]   r_da, r_db, r_dc, r_sum, r_res;

    logic            r_out_valid;
    tlca_pkg::t_rsp  r_out;

    logic [NW-1:0]   a_idx, b_idx;
    logic [LIM_W-1:0] lim;
    logic            sub_a, sub_b;
    logic            holds_ab, holds_ba, holds_up;
    logic [TW-1:0]   up_entry, up_exit;
    logic [LW-1:0]   lvl_prev;

    logic            anc_we;
    logic [AW-1:0]   anc_waddr, anc_raddr;
    logic [NW-1:0]   anc_wdata;
    logic            tbl_we;
    logic [NW-1:0]   tbl_raddr;

    assign a_idx    = NW'(r_ra);
    assign b_idx    = NW'(r_rb);
    assign lvl_prev = r_lvl - LW'(1);

    // one restoring step of the modulo-NODES reduction per cycle
    assign lim   = LIM_W'(NODES) << r_step;
    assign sub_a = LIM_W'(r_ra) >= lim;
    assign sub_b = LIM_W'(r_rb) >= lim;

    assign up_entry = r_span_q[2*TW-1:TW];
    assign up_exit  = r_span_q[TW-1:0];
    assign holds_ab = (r_ea <= r_eb) && (r_eb <= r_xa);
    assign holds_ba = (r_eb <= r_ea) && (r_ea <= r_xb);
    assign holds_up = (up_entry <= r_eb) && (r_eb <= up_exit);

    assign o_stat.is_query  = (r_type == tlca_pkg::REQ_QUERY);
    assign o_stat.step_last = (r_step == '0);
    assign o_stat.lvl_last  = (r_lvl == LW'(LEVELS - 1));
    assign o_stat.lvl_zero  = (r_lvl == '0);
    assign o_stat.contained = holds_ab || holds_ba;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        anc_we    = 1'b0;
        anc_waddr = '0;
        anc_wdata = '0;
        anc_raddr = '0;
        tbl_we    = 1'b0;
        tbl_raddr = '0;
        case (i_cmd.op)
            tlca_pkg::OP_LOAD_WRITE: begin
                anc_we    = 1'b1;
                anc_waddr = {a_idx, LW'(0)};
                anc_wdata = b_idx;
                tbl_we    = 1'b1;
            end
            tlca_pkg::OP_FILL_READ:   anc_raddr = {r_up, lvl_prev};
            tlca_pkg::OP_FILL_WRITE: begin
                anc_we    = 1'b1;
                anc_waddr = {a_idx, r_lvl};
                anc_wdata = r_anc_q;
            end
            tlca_pkg::OP_READ_A:      tbl_raddr = a_idx;
            tlca_pkg::OP_READ_B:      tbl_raddr = b_idx;
            tlca_pkg::OP_CLIMB_READ:  anc_raddr = {r_cur, r_lvl};
            tlca_pkg::OP_CLIMB_SPAN:  tbl_raddr = r_anc_q;
            tlca_pkg::OP_PARENT_READ: anc_raddr = {r_cur, LW'(0)};
            tlca_pkg::OP_DIST_READ:   tbl_raddr = r_anc_q;
            default: begin
                anc_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (anc_we) r_anc_mem[anc_waddr] <= anc_wdata;
        r_anc_q <= r_anc_mem[anc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_span_mem[a_idx] <= {r_entry, r_exit};
            r_dist_mem[a_idx] <= r_rdist;
        end
        r_span_q <= r_span_mem[tbl_raddr];
        r_dist_q <= r_dist_mem[tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tlca_pkg::OP_CAPTURE: begin
                r_type  <= i_req.req_type;
                r_ra    <= i_req.node_a;
                r_rb    <= i_req.node_b;
                r_entry <= i_req.entry_time;
                r_exit  <= i_req.exit_time;
                r_rdist <= i_req.root_distance;
                r_step  <= tlca_pkg::STEP_W'(FW - 1);
            end
            tlca_pkg::OP_REDUCE: begin
                if (sub_a) r_ra <= r_ra - FW'(lim);
                if (sub_b) r_rb <= r_rb - FW'(lim);
                r_step <= r_step - tlca_pkg::STEP_W'(1);
            end
            tlca_pkg::OP_LOAD_WRITE: begin
                r_up  <= b_idx;
                r_lvl <= LW'(1);
            end
            tlca_pkg::OP_FILL_WRITE: begin
                r_up  <= r_anc_q;
                r_lvl <= r_lvl + LW'(1);
            end
            tlca_pkg::OP_READ_B: begin
                r_ea <= up_entry;
                r_xa <= up_exit;
                r_da <= r_dist_q;
            end
            tlca_pkg::OP_CAPTURE_B: begin
                r_eb <= up_entry;
                r_xb <= up_exit;
                r_db <= r_dist_q;
            end
            tlca_pkg::OP_CHECK: begin
                r_sum <= r_da + r_db;
                r_cur <= a_idx;
                r_lvl <= LW'(LEVELS - 1);
                if (holds_ab) begin
                    r_c  <= a_idx;
                    r_dc <= r_da;
                end else if (holds_ba) begin
                    r_c  <= b_idx;
                    r_dc <= r_db;
                end
            end
            tlca_pkg::OP_CLIMB_SPAN: r_up <= r_anc_q;
            tlca_pkg::OP_CLIMB_TEST: begin
                if (!holds_up) r_cur <= r_up;
                r_lvl <= lvl_prev;
            end
            tlca_pkg::OP_DIST_READ:    r_c   <= r_anc_q;
            tlca_pkg::OP_DIST_CAPTURE: r_dc  <= r_dist_q;
            tlca_pkg::OP_FINISH:       r_res <= r_sum - {r_dc[DW-2:0], 1'b0};
            tlca_pkg::OP_OUT_LOAD: begin
                r_out.result_kind <= o_stat.is_query ? tlca_pkg::RES_QUERY
                                                     : tlca_pkg::RES_LOAD;
                r_out.common_ancestor <= o_stat.is_query ? FW'(r_c) : '0;
                r_out.path_distance   <= o_stat.is_query ? r_res : '0;
            end
            default: begin
                r_type <= r_type;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == tlca_pkg::OP_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- rtl/core/tree_lca_distance_query_core.sv -----
// ----------------------------------------------------------------------------
// tree_lca_distance_query_core - lowest common ancestor engine
// Binary-lifting ancestor store with load and query items.
// ----------------------------------------------------------------------------
// A load item stores one node (entry/exit time, root distance, parent) and
// fills its ancestor row by doubling; loads must arrive in preorder with the
// root naming itself as parent. A query item returns the lowest common
// ancestor of two nodes and the weighted path length between them, modulo
// 2^32. Every item yields exactly one result item. Items are handled one at
// a time: node indexes are first reduced modulo NODES; a load then writes
// its node and fills the higher ancestor levels one by one, and a query
// reads the times and distances of both nodes, then either finds that one
// holds the other or climbs the levels from the top down and reads the
// common ancestor and its distance, then hands the result to the output
// register. The climb dominates: every level is a registered read of the
// ancestor memory followed by a registered read of the time memory. The
// output register lets a new item be taken while the last result waits.
// Memories are not cleared at reset; a node must be loaded before any item
// reads it.
// ----------------------------------------------------------------------------
module tree_lca_distance_query_core #(
    parameter int NODES  = tlca_pkg::NODES_DEF,
    parameter int LEVELS = tlca_pkg::LEVELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlca_stream_if.sink   i_req,
    tlca_stream_if.source o_rsp
);

    tlca_pkg::t_cmd  cmd;
    tlca_pkg::t_stat stat;
    logic            req_ready;
    logic            out_valid;
    tlca_pkg::t_rsp  out_item;

    // sequencer: one item in flight, ready only while idle
    tlca_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // memories, reduction, climb and output register
    tlca_dpath #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req.payload),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_out       (out_item)
    );

    assign i_req.ready   = req_ready;
    assign o_rsp.valid   = out_valid;
    assign o_rsp.payload = out_item;

endmodule

// ----- rtl/core/tlca_checker.sv -----
// ----------------------------------------------------------------------------
// tlca_checker - port-level checks of the tree ancestor engine
// Watches item flow on the request and result channels.
// ----------------------------------------------------------------------------
module tlca_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input tlca_pkg::t_rsp i_rsp
);

    logic [1:0] r_pending;
    logic [1:0] n_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_req_valid && i_req_ready;
    assign out_acc = i_rsp_valid && i_rsp_ready;

    always_comb begin
        n_pending = r_pending + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("result item changed while stalled");

    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.result_kind == tlca_pkg::RES_LOAD)
        |-> (i_rsp.common_ancestor == '0) && (i_rsp.path_distance == '0))
        else $error("load acknowledge carries nonzero fields");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_pending != 2'd0))
        else $error("result item without an accepted request");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_req_ready)
        else $error("request taken while an item is in work");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two items outstanding");

endmodule

bind tree_lca_distance_query_core tlca_checker u_tlca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);
